FILE: rtl/obb_pkg.sv
// Package for the oriented-box separating-axis test.
// Holds box counts, op codes, datapath widths and the queue entry type.
package obb_pkg;

  localparam int CORNERS_PER_BOX = 8;
  localparam int NORMALS_PER_BOX = 6;
  localparam int NUM_CORNERS     = 2 * CORNERS_PER_BOX;
  localparam int NUM_NORMALS     = 2 * NORMALS_PER_BOX;
  localparam int CIDX_W          = $clog2(NUM_CORNERS);
  localparam int NIDX_W          = $clog2(NUM_NORMALS);
  localparam int KIDX_W          = (CORNERS_PER_BOX > 1) ? $clog2(CORNERS_PER_BOX) : 1;

  localparam int COMP_W = 32;
  localparam int SUM_W  = 33;
  localparam int PROD_W = 65;
  localparam int DOT_W  = 67;

  localparam logic [2:0] OP_CORNER_A = 3'd0;
  localparam logic [2:0] OP_CORNER_B = 3'd1;
  localparam logic [2:0] OP_NORMAL_A = 3'd2;
  localparam logic [2:0] OP_NORMAL_B = 3'd3;
  localparam logic [2:0] OP_POS_A    = 3'd4;
  localparam logic [2:0] OP_POS_B    = 3'd5;
  localparam logic [2:0] OP_TEST     = 3'd6;

  typedef enum logic [1:0] {
    KIND_CORNER = 2'd0,
    KIND_NORMAL = 2'd1,
    KIND_POS    = 2'd2,
    KIND_TEST   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e                     kind;
    logic                      box;
    logic [2:0]                slot;
    logic signed [COMP_W-1:0]  vx;
    logic signed [COMP_W-1:0]  vy;
    logic signed [COMP_W-1:0]  vz;
  } cmd_t;

endpackage

FILE: rtl/obb_if.sv
// Valid/ready channel interfaces for the box test.
// Depends on obb_pkg for field widths.
interface obb_in_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          op;
  logic [2:0]                          slot;
  logic signed [obb_pkg::COMP_W-1:0]   vx;
  logic signed [obb_pkg::COMP_W-1:0]   vy;
  logic signed [obb_pkg::COMP_W-1:0]   vz;
  modport source (output valid, op, slot, vx, vy, vz, input ready);
  modport sink   (input valid, op, slot, vx, vy, vz, output ready);
endinterface

interface obb_out_if;
  logic valid;
  logic ready;
  logic intersects;
  modport source (output valid, intersects, input ready);
  modport sink   (input valid, intersects, output ready);
endinterface

FILE: rtl/obb_front.sv
// Front end: accepts items, classifies them and drops unused ops or bad slots.
// Depends on obb_pkg and obb_if.
module obb_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  obb_in_if.sink         in_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output obb_pkg::cmd_t  cmd_o
);

  obb_pkg::cmd_t cmd_q, cmd_d;
  logic          valid_q;
  logic          keep;

  assign in_i.ready  = !valid_q || cmd_ready_i;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  // Classify the op and check the slot range
  always_comb begin
    cmd_d      = '0;
    cmd_d.box  = in_i.op[0];
    cmd_d.slot = in_i.slot;
    cmd_d.vx   = in_i.vx;
    cmd_d.vy   = in_i.vy;
    cmd_d.vz   = in_i.vz;
    keep       = 1'b0;
    case (in_i.op)
      obb_pkg::OP_CORNER_A, obb_pkg::OP_CORNER_B: begin
        cmd_d.kind = obb_pkg::KIND_CORNER;
        keep = 32'(in_i.slot) < obb_pkg::CORNERS_PER_BOX;
      end
      obb_pkg::OP_NORMAL_A, obb_pkg::OP_NORMAL_B: begin
        cmd_d.kind = obb_pkg::KIND_NORMAL;
        keep = 32'(in_i.slot) < obb_pkg::NORMALS_PER_BOX;
      end
      obb_pkg::OP_POS_A, obb_pkg::OP_POS_B: begin
        cmd_d.kind = obb_pkg::KIND_POS;
        keep = 1'b1;
      end
      obb_pkg::OP_TEST: begin
        cmd_d.kind = obb_pkg::KIND_TEST;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  // Hold one classified beat toward the back end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

FILE: rtl/obb_fifo.sv
// Short command queue between front and back end.
// Depends on obb_pkg for the entry type.
module obb_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  obb_pkg::cmd_t  data_i,
  input  logic           pop_i,
  output logic           empty_o,
  output obb_pkg::cmd_t  data_o
);

  localparam int DEPTH = 4;

  obb_pkg::cmd_t mem_q [DEPTH];
  logic [1:0]    wptr_q, rptr_q;
  logic [2:0]    cnt_q;

  assign full_o  = cnt_q == 3'(DEPTH);
  assign empty_o = cnt_q == 3'd0;
  assign data_o  = mem_q[rptr_q];

  // Write the entry at the tail
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i && !full_o) wptr_q <= wptr_q + 2'd1;
      if (pop_i && !empty_o) rptr_q <= rptr_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_i && !full_o) - 3'(pop_i && !empty_o);
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(DEPTH)) else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |=> cnt_q <= 3'd1) else $error("count moved from empty");
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !pop_i) |=> full_o) else $error("full queue lost entry");
`endif

endmodule

FILE: rtl/obb_back.sv
// Back end: stores box data and runs the axis sweep for test commands.
// Depends on obb_pkg and obb_if.
module obb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  obb_pkg::cmd_t  cmd_i,
  output logic           cmd_pop_o,
  obb_out_if.source      out_o
);

  localparam int CW = obb_pkg::COMP_W;
  localparam int SW = obb_pkg::SUM_W;
  localparam int PW = obb_pkg::PROD_W;
  localparam int DW = obb_pkg::DOT_W;
  localparam int CPB = obb_pkg::CORNERS_PER_BOX;
  localparam int NN  = obb_pkg::NUM_NORMALS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic signed [CW-1:0] cx_q [obb_pkg::NUM_CORNERS];
  logic signed [CW-1:0] cy_q [obb_pkg::NUM_CORNERS];
  logic signed [CW-1:0] cz_q [obb_pkg::NUM_CORNERS];
  logic signed [CW-1:0] nx_q [NN];
  logic signed [CW-1:0] ny_q [NN];
  logic signed [CW-1:0] nz_q [NN];
  logic signed [CW-1:0] px_q [2];
  logic signed [CW-1:0] py_q [2];
  logic signed [CW-1:0] pz_q [2];

  logic [1:0]                   state_q;
  logic [obb_pkg::NIDX_W-1:0]   axis_q;
  logic                         box_q;
  logic [obb_pkg::KIDX_W-1:0]   corner_q;
  logic                         res_q, out_valid_q;

  // stage 1: corner offsets
  logic                         s1_v_q, s1_box_q, s1_first_q, s1_last_q, s1_alast_q;
  logic signed [SW-1:0]         ax_q, ay_q, az_q;
  logic signed [CW-1:0]         bx_q, by_q, bz_q;
  // stage 2: products
  logic                         s2_v_q, s2_box_q, s2_first_q, s2_last_q, s2_alast_q;
  logic signed [PW-1:0]         mx_q, my_q, mz_q;
  // stage 3: dot product
  logic                         s3_v_q, s3_box_q, s3_first_q, s3_last_q, s3_alast_q;
  logic signed [DW-1:0]         dot_q;
  logic signed [DW-1:0]         amin_q, amax_q, bmin_q, bmax_q;
  logic signed [DW-1:0]         cmin, cmax;
  logic                         issue;
  logic [obb_pkg::CIDX_W-1:0]   cidx;

  assign out_o.valid      = out_valid_q;
  assign out_o.intersects = res_q;
  assign cmd_pop_o = !cmd_empty_i && state_q == ST_IDLE;
  assign issue     = state_q == ST_RUN;
  assign cidx      = obb_pkg::CIDX_W'(32'(box_q) * CPB + 32'(corner_q));

  // Write loads into the register file
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      case (cmd_i.kind)
        obb_pkg::KIND_CORNER: begin
          cx_q[obb_pkg::CIDX_W'(32'(cmd_i.box) * CPB + 32'(cmd_i.slot))] <= cmd_i.vx;
          cy_q[obb_pkg::CIDX_W'(32'(cmd_i.box) * CPB + 32'(cmd_i.slot))] <= cmd_i.vy;
          cz_q[obb_pkg::CIDX_W'(32'(cmd_i.box) * CPB + 32'(cmd_i.slot))] <= cmd_i.vz;
        end
        obb_pkg::KIND_NORMAL: begin
          nx_q[obb_pkg::NIDX_W'(32'(cmd_i.box) * obb_pkg::NORMALS_PER_BOX
               + 32'(cmd_i.slot))] <= cmd_i.vx;
          ny_q[obb_pkg::NIDX_W'(32'(cmd_i.box) * obb_pkg::NORMALS_PER_BOX
               + 32'(cmd_i.slot))] <= cmd_i.vy;
          nz_q[obb_pkg::NIDX_W'(32'(cmd_i.box) * obb_pkg::NORMALS_PER_BOX
               + 32'(cmd_i.slot))] <= cmd_i.vz;
        end
        obb_pkg::KIND_POS: begin
          px_q[cmd_i.box] <= cmd_i.vx;
          py_q[cmd_i.box] <= cmd_i.vy;
          pz_q[cmd_i.box] <= cmd_i.vz;
        end
        default: ;
      endcase
    end
  end

  // Sequence the sweep over axes, boxes and corners
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= '0;
      box_q       <= 1'b0;
      corner_q    <= '0;
      out_valid_q <= 1'b0;
      res_q       <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o && cmd_i.kind == obb_pkg::KIND_TEST) begin
            state_q  <= ST_RUN;
            axis_q   <= '0;
            box_q    <= 1'b0;
            corner_q <= '0;
            res_q    <= 1'b1;
          end
        end
        ST_RUN: begin
          if (32'(corner_q) == CPB - 1) begin
            corner_q <= '0;
            box_q    <= !box_q;
            if (box_q) begin
              if (32'(axis_q) == NN - 1) state_q <= ST_OUT;
              else axis_q <= axis_q + 1'b1;
            end
          end else begin
            corner_q <= corner_q + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_valid_q && out_o.ready) begin
            out_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end else if (!s1_v_q && !s2_v_q && !s3_v_q) begin
            out_valid_q <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      // clear the result on an axis that separates the intervals
      if (s3_v_q && s3_alast_q && s3_box_q && s3_last_q) begin
        if (!((cmin >= amin_q && cmin <= amax_q) ||
              (amin_q >= cmin && amin_q <= cmax))) begin
          res_q <= 1'b0;
        end
      end
    end
  end

  // Pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // Offset the corner by the box position, fetch the normal
  always_ff @(posedge clk_i) begin
    s1_box_q   <= box_q;
    s1_first_q <= corner_q == '0;
    s1_last_q  <= 32'(corner_q) == CPB - 1;
    s1_alast_q <= 1'b1;
    ax_q <= SW'(cx_q[cidx]) + SW'(px_q[box_q]);
    ay_q <= SW'(cy_q[cidx]) + SW'(py_q[box_q]);
    az_q <= SW'(cz_q[cidx]) + SW'(pz_q[box_q]);
    bx_q <= nx_q[axis_q];
    by_q <= ny_q[axis_q];
    bz_q <= nz_q[axis_q];
  end

  // Multiply components
  always_ff @(posedge clk_i) begin
    s2_box_q   <= s1_box_q;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_alast_q <= s1_alast_q;
    mx_q <= PW'(ax_q) * PW'(bx_q);
    my_q <= PW'(ay_q) * PW'(by_q);
    mz_q <= PW'(az_q) * PW'(bz_q);
  end

  // Sum the three products
  always_ff @(posedge clk_i) begin
    s3_box_q   <= s2_box_q;
    s3_first_q <= s2_first_q;
    s3_last_q  <= s2_last_q;
    s3_alast_q <= s2_alast_q;
    dot_q <= DW'(mx_q) + DW'(my_q) + DW'(mz_q);
  end

  // Running interval for the current box, seeded by the first corner
  always_comb begin
    cmin = s3_box_q ? bmin_q : amin_q;
    cmax = s3_box_q ? bmax_q : amax_q;
    if (s3_first_q || dot_q <= cmin) cmin = dot_q;
    if (s3_first_q || dot_q >= cmax) cmax = dot_q;
  end

  always_ff @(posedge clk_i) begin
    if (s3_v_q) begin
      if (s3_box_q) begin
        bmin_q <= cmin;
        bmax_q <= cmax;
      end else begin
        amin_q <= cmin;
        amax_q <= cmax;
      end
    end
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> state_q == ST_IDLE) else $error("pop while busy");
  a_out_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !s3_v_q) else $error("result before pipe drained");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> out_valid_q && $stable(res_q))
    else $error("result changed while stalled");
`endif

endmodule

FILE: rtl/obb_separating_axis_test.sv
// Oriented-box separating-axis test: the back end pops and writes loads while it is idle.
// A test sweeps 12 axes x 2 boxes x 8 corners = 192 corner projections through a
// three-stage project pipeline, then drains the pipeline and presents the result.
// Front register and a four-entry queue let loads arrive while a test runs.
// Reset clears control only; box data stays undefined until written.
module obb_separating_axis_test (
  input  logic    clk_i,
  input  logic    rst_ni,
  obb_in_if.sink  in_i,
  obb_out_if.source out_o
);

  obb_pkg::cmd_t fcmd, qcmd;
  logic          fvalid, full, empty, pop;

  obb_front u_front (
    .clk_i, .rst_ni, .in_i,
    .cmd_valid_o(fvalid), .cmd_ready_i(!full), .cmd_o(fcmd)
  );

  obb_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(fvalid), .full_o(full), .data_i(fcmd),
    .pop_i(pop), .empty_o(empty), .data_o(qcmd)
  );

  obb_back u_back (
    .clk_i, .rst_ni,
    .cmd_empty_i(empty), .cmd_i(qcmd), .cmd_pop_o(pop), .out_o
  );

endmodule

FILE: tb/obb_separating_axis_test_tb.sv
// Testbench for obb_separating_axis_test: loads box data, runs tests, scores each intersect bit.
// Depends on obb_pkg, obb_in_if and obb_out_if.
`timescale 1ns / 100ps

module obb_separating_axis_test_tb;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 400;

  // Intersect predictor with its own copy of both boxes
  class obb_scoreboard;
    logic signed [31:0] cx[obb_pkg::NUM_CORNERS], cy[obb_pkg::NUM_CORNERS];
    logic signed [31:0] cz[obb_pkg::NUM_CORNERS];
    logic signed [31:0] nx[obb_pkg::NUM_NORMALS], ny[obb_pkg::NUM_NORMALS];
    logic signed [31:0] nz[obb_pkg::NUM_NORMALS];
    logic signed [31:0] px[2], py[2], pz[2];
    bit pending_hits[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function logic signed [66:0] mul_term(logic signed [31:0] c, logic signed [31:0] p,
                                          logic signed [31:0] n);
      logic signed [66:0] s, m;
      s = 67'(c) + 67'(p);
      m = 67'(n);
      return s * m;
    endfunction

    function bit boxes_overlap();
      logic signed [66:0] d, lo[2], hi[2];
      int ci;
      for (int a = 0; a < obb_pkg::NUM_NORMALS; a++) begin
        for (int b = 0; b < 2; b++) begin
          for (int k = 0; k < obb_pkg::CORNERS_PER_BOX; k++) begin
            ci = b * obb_pkg::CORNERS_PER_BOX + k;
            d = mul_term(cx[ci], px[b], nx[a]) + mul_term(cy[ci], py[b], ny[a])
                + mul_term(cz[ci], pz[b], nz[a]);
            if (k == 0 || d < lo[b]) lo[b] = d;
            if (k == 0 || d > hi[b]) hi[b] = d;
          end
        end
        if (!((lo[1] >= lo[0] && lo[1] <= hi[0]) || (lo[0] >= lo[1] && lo[0] <= hi[1])))
          return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_input(logic [2:0] op, logic [2:0] slot, logic signed [31:0] x,
                             logic signed [31:0] y, logic signed [31:0] z);
      int i;
      case (op)
        obb_pkg::OP_CORNER_A, obb_pkg::OP_CORNER_B: begin
          if (slot < obb_pkg::CORNERS_PER_BOX) begin
            i = op[0] * obb_pkg::CORNERS_PER_BOX + slot;
            cx[i] = x; cy[i] = y; cz[i] = z;
          end
        end
        obb_pkg::OP_NORMAL_A, obb_pkg::OP_NORMAL_B: begin
          if (slot < obb_pkg::NORMALS_PER_BOX) begin
            i = op[0] * obb_pkg::NORMALS_PER_BOX + slot;
            nx[i] = x; ny[i] = y; nz[i] = z;
          end
        end
        obb_pkg::OP_POS_A, obb_pkg::OP_POS_B: begin
          px[op[0]] = x; py[op[0]] = y; pz[op[0]] = z;
        end
        obb_pkg::OP_TEST: pending_hits.push_back(boxes_overlap());
        default: ;
      endcase
    endfunction

    function void check_result(logic hit);
      bit exp_hit;
      if (pending_hits.size() == 0) begin
        $error("unexpected result beat: intersects actual %0b", hit);
        errors++;
        return;
      end
      exp_hit = pending_hits.pop_front();
      if (hit !== exp_hit) begin
        $error("intersects mismatch: expected %0b actual %0b", exp_hit, hit);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  obb_in_if  in_if();
  obb_out_if out_if();
  obb_scoreboard sb;
  int cycles;
  bit in_burst, out_burst;

  obb_separating_axis_test u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter with timeout
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: random stalls, with stretches of steady ready
  initial begin
    out_if.ready = 1'b0;
    out_burst = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 49) == 0) out_burst = ~out_burst;
      if (out_burst) out_if.ready <= 1'b1;
      else if ($urandom_range(0, 99) < 3) out_if.ready <= 1'b0;
      else out_if.ready <= ($urandom_range(0, 2) != 0);
    end
  end

  // Score every accepted result beat
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.intersects);
  end

  // Drive one beat; hold valid until accepted
  task automatic send_beat(logic [2:0] op, logic [2:0] slot, logic [31:0] x,
                           logic [31:0] y, logic [31:0] z);
    int gap;
    gap = in_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.op <= op; in_if.slot <= slot;
    in_if.vx <= x; in_if.vy <= y; in_if.vz <= z;
    in_if.valid <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(op, slot, x, y, z);
    @(negedge clk_i);
    if ($urandom_range(0, 39) == 0) in_burst = ~in_burst;
  endtask

  // Load a cube-like box: corners at +-half size, axis or skewed normals, position
  task automatic load_box(bit b, logic signed [31:0] hx, logic signed [31:0] hy,
                          logic signed [31:0] hz, logic signed [31:0] ox,
                          logic signed [31:0] oy, logic signed [31:0] oz, bit skew);
    logic signed [31:0] u;
    for (int k = 0; k < obb_pkg::CORNERS_PER_BOX; k++)
      send_beat(b ? obb_pkg::OP_CORNER_B : obb_pkg::OP_CORNER_A, k[2:0], k[0] ? hx : -hx,
                k[1] ? hy : -hy, k[2] ? hz : -hz);
    for (int k = 0; k < obb_pkg::NORMALS_PER_BOX; k++) begin
      u = (k % 2) ? -32'sh10000 : 32'sh10000;
      if (skew)
        send_beat(b ? obb_pkg::OP_NORMAL_B : obb_pkg::OP_NORMAL_A, k[2:0],
                  $urandom_range(0, 32'h20000) - 32'h10000,
                  $urandom_range(0, 32'h20000) - 32'h10000,
                  $urandom_range(0, 32'h20000) - 32'h10000);
      else
        send_beat(b ? obb_pkg::OP_NORMAL_B : obb_pkg::OP_NORMAL_A, k[2:0],
                  (k / 2 == 0) ? u : 0, (k / 2 == 1) ? u : 0, (k / 2 == 2) ? u : 0);
    end
    send_beat(b ? obb_pkg::OP_POS_B : obb_pkg::OP_POS_A, 3'd0, ox, oy, oz);
  endtask

  function logic [31:0] small_val(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  initial begin
    logic [31:0] big;
    sb = new();
    in_burst = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = OP_UNUSED; in_if.slot = 3'd0;
    in_if.vx = 0; in_if.vy = 0; in_if.vz = 0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: touching boxes (inclusive bound), separated, overlapping
    load_box(1'b0, 32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 0, 1'b0);
    load_box(1'b1, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh20000, 0, 0, 1'b0);
    send_beat(obb_pkg::OP_TEST, 3'd0, 0, 0, 0);
    send_beat(obb_pkg::OP_POS_B, 3'd5, 32'sh20001, 0, 0);
    send_beat(obb_pkg::OP_TEST, 3'd7, 32'hffffffff, 0, 32'h80000000);
    send_beat(obb_pkg::OP_POS_B, 3'd0, 32'sh8000, 32'sh8000, 0);
    send_beat(obb_pkg::OP_TEST, 3'd0, 0, 0, 0);
    // Out-of-range normal slots and the unused op leave the boxes as they are; corner slot 7 is a valid write
    send_beat(obb_pkg::OP_CORNER_A, 3'd7, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_beat(obb_pkg::OP_NORMAL_B, 3'd6, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_beat(obb_pkg::OP_NORMAL_A, 3'd7, 32'h80000000, 32'h80000000, 32'h80000000);
    send_beat(OP_UNUSED, 3'd3, 32'h12345678, 32'h9abcdef0, 32'hffffffff);
    send_beat(obb_pkg::OP_TEST, 3'd0, 0, 0, 0);
    // Extreme magnitudes in every field
    send_beat(obb_pkg::OP_CORNER_B, 3'd0, 32'h80000000, 32'h80000000, 32'h80000000);
    send_beat(obb_pkg::OP_NORMAL_A, 3'd0, 32'h80000000, 32'h80000000, 32'h80000000);
    send_beat(obb_pkg::OP_POS_B, 3'd0, 32'h80000000, 32'h80000000, 32'h80000000);
    send_beat(obb_pkg::OP_TEST, 3'd0, 0, 0, 0);
    send_beat(obb_pkg::OP_POS_A, 3'd0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_beat(obb_pkg::OP_CORNER_A, 3'd7, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_beat(obb_pkg::OP_NORMAL_B, 3'd5, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_beat(obb_pkg::OP_TEST, 3'd0, 0, 0, 0);

    // Random: mostly well-formed box reloads and tests, some noise beats
    for (int n = 0; n < 64; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: load_box(1'($urandom_range(0, 1)), $urandom_range(1, 32'h40000),
                             $urandom_range(1, 32'h40000), $urandom_range(1, 32'h40000),
                             small_val(32'h80000), small_val(32'h80000),
                             small_val(32'h80000), $urandom_range(0, 2) == 0);
        4, 5: send_beat(3'($urandom_range(obb_pkg::OP_POS_A, obb_pkg::OP_POS_B)),
                        3'($urandom), small_val(32'h60000), small_val(32'h60000),
                        small_val(32'h60000));
        6: send_beat(3'($urandom_range(obb_pkg::OP_CORNER_A, obb_pkg::OP_CORNER_B)),
                     3'($urandom), small_val(32'h40000), small_val(32'h40000),
                     small_val(32'h40000));
        7: begin
          // Full-width noise reaches every bit of every field
          for (int j = 0; j < 4; j++) begin
            big = $urandom;
            send_beat(3'($urandom_range(0, 7)), 3'($urandom), big, $urandom, $urandom);
          end
        end
        default: ;
      endcase
      repeat ($urandom_range(1, 3))
        send_beat(obb_pkg::OP_TEST, 3'($urandom), $urandom, $urandom, $urandom);
    end

    in_if.valid <= 1'b0;
    while (sb.pending_hits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_hits.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

FILE: sim.f
rtl/obb_pkg.sv
rtl/obb_if.sv
rtl/obb_front.sv
rtl/obb_fifo.sv
rtl/obb_back.sv
rtl/obb_separating_axis_test.sv
tb/obb_separating_axis_test_tb.sv
